[hdl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, widths and constants of the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // field and register widths
    localparam int RATE_W     = 24;
    localparam int DT_W       = 20;
    localparam int CPR_W      = 16;
    localparam int RAD_W      = 20;
    localparam int TRK_W      = 22;
    localparam int SPD_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CPR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRK = 2'd2;

    // register reset values
    localparam logic [CPR_W-1:0] CPR_RESET = 16'd6000;
    localparam logic [RAD_W-1:0] RAD_RESET = 20'd47500;
    localparam logic [TRK_W-1:0] TRK_RESET = 22'd350000;

    // serial multiplier: 64 x 32 bits, one multiplier bit per cycle
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    // serial divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = 6;

    // cordic
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_CNT_W = 5;
    localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 34'd652032874;
    localparam int TRIG_W = 32;

    // arithmetic constants
    localparam logic [MUL_B_W-1:0] TWO_PI_Q16   = 32'd411775;
    localparam logic [MUL_B_W-1:0] TURN_PER_RAD = 32'd683565276;
    localparam logic [DIV_D_W-1:0] US_DIV       = 32'd15625;
    localparam logic [DIV_N_W-1:0] US_ROUND     = 64'd7812;
    localparam logic [SPD_W-1:0]   SPD_MAX      = 32'h7FFF_FFFF;
    localparam logic [SPD_W-1:0]   SPD_MIN      = 32'h8000_0000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_MUL1,
        ST_R_MUL2,
        ST_R_DIV,
        ST_T_TRIG,
        ST_T_MULS,
        ST_T_DIVS,
        ST_T_MULX,
        ST_T_MULY,
        ST_T_MULD,
        ST_T_DIVD,
        ST_T_DIVR,
        ST_T_MULA,
        ST_OUT
    } t_state;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] f_atan(input logic [CORDIC_CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/ddo_in_if.sv]
// ----------------------------------------------------------------------------
// ddo_in_if
// Request channel: a wheel-rate update or a time tick.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [ddo_pkg::RATE_W-1:0]   left_rate;
    logic signed [ddo_pkg::RATE_W-1:0]   right_rate;
    logic        [ddo_pkg::DT_W-1:0]     elapsed_us;

    modport source (output valid, action, left_rate, right_rate, elapsed_us, input ready);
    modport sink   (input valid, action, left_rate, right_rate, elapsed_us, output ready);
endinterface

[hdl/ddo_out_if.sv]
// ----------------------------------------------------------------------------
// ddo_out_if
// Pose channel: position and heading after each request.
// ----------------------------------------------------------------------------
interface ddo_out_if #(
    parameter int POS_BITS   = 40,
    parameter int ANGLE_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] pose_x_um;
    logic signed [POS_BITS-1:0] pose_y_um;
    logic [ANGLE_BITS-1:0]      heading;

    modport source (output valid, pose_x_um, pose_y_um, heading, input ready);
    modport sink   (input valid, pose_x_um, pose_y_um, heading, output ready);
endinterface

[hdl/ddo_mul.sv]
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ddo_pkg::MUL_A_W-1:0]    i_a,
    input  logic [ddo_pkg::MUL_B_W-1:0]    i_b,
    output logic                           o_done,
    output logic [ddo_pkg::MUL_P_W-1:0]    o_p
);

    logic [ddo_pkg::MUL_A_W-1:0]   r_a;
    logic [ddo_pkg::MUL_P_W-1:0]   r_p;
    logic [ddo_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [ddo_pkg::MUL_A_W:0]     w_hi;

    // upper half plus the multiplicand when the low bit is set
    assign w_hi = {1'b0, r_p[ddo_pkg::MUL_P_W-1:ddo_pkg::MUL_B_W]}
                + (r_p[0] ? {1'b0, r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ddo_pkg::MUL_CNT_W'(ddo_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{ddo_pkg::MUL_A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_hi, r_p[ddo_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

[hdl/ddo_div.sv]
// ----------------------------------------------------------------------------
// ddo_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ddo_pkg::DIV_N_W-1:0]    i_n,
    input  logic [ddo_pkg::DIV_D_W-1:0]    i_d,
    output logic                           o_done,
    output logic [ddo_pkg::DIV_N_W-1:0]    o_q
);

    logic [ddo_pkg::DIV_N_W-1:0]   r_n;
    logic [ddo_pkg::DIV_D_W-1:0]   r_d;
    logic [ddo_pkg::DIV_D_W-1:0]   r_rem;
    logic [ddo_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [ddo_pkg::DIV_D_W:0]     w_trial;
    logic [ddo_pkg::DIV_D_W:0]     w_diff;
    logic                          w_qbit;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_n[ddo_pkg::DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_qbit  = (w_trial >= {1'b0, r_d});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[ddo_pkg::DIV_N_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[ddo_pkg::DIV_D_W-1:0] : w_trial[ddo_pkg::DIV_D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_q    = r_n;

endmodule

[hdl/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation CORDIC: cosine and sine of a 32-bit turn angle in Q30.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [31:0]                        i_turn,
    output logic                               o_done,
    output logic signed [ddo_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [ddo_pkg::TRIG_W-1:0]  o_sin
);

    logic signed [ddo_pkg::CORDIC_W-1:0]  r_x;
    logic signed [ddo_pkg::CORDIC_W-1:0]  r_y;
    logic signed [ddo_pkg::CORDIC_W-1:0]  r_z;
    logic                                 r_flip;
    logic [ddo_pkg::CORDIC_CNT_W-1:0]     r_i;
    logic                                 r_busy;
    logic                                 r_done;
    logic                                 w_flip;
    logic [31:0]                          w_zf;
    logic signed [ddo_pkg::CORDIC_W-1:0]  w_dx;
    logic signed [ddo_pkg::CORDIC_W-1:0]  w_dy;
    logic signed [ddo_pkg::CORDIC_W-1:0]  w_at;
    logic signed [ddo_pkg::CORDIC_W-1:0]  w_nx;
    logic signed [ddo_pkg::CORDIC_W-1:0]  w_ny;

    // fold the second and third quarter by a half turn
    assign w_flip = i_turn[31] ^ i_turn[30];
    assign w_zf   = w_flip ? {~i_turn[31], i_turn[30:0]} : i_turn;

    // one micro-rotation
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = signed'(ddo_pkg::CORDIC_W'(ddo_pkg::f_atan(r_i)));

    // undo the fold
    assign w_nx = r_flip ? -r_x : r_x;
    assign w_ny = r_flip ? -r_y : r_y;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == ddo_pkg::CORDIC_CNT_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotation datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= signed'(ddo_pkg::CORDIC_GAIN);
            r_y    <= '0;
            r_z    <= signed'({{(ddo_pkg::CORDIC_W - 32){w_zf[31]}}, w_zf});
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[ddo_pkg::CORDIC_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = w_nx[ddo_pkg::TRIG_W-1:0];
    assign o_sin  = w_ny[ddo_pkg::TRIG_W-1:0];

endmodule

[hdl/differential_drive_odometry.sv]
// Dead-reckoning odometry for a two-wheel robot. Each request either latches
// new left/right encoder rates (action 0), which are turned into wheel speeds
// in um/s, or integrates one time tick of elapsed_us (action 1), moving x/y
// along the heading held before the tick and turning the heading by the speed
// difference over the track width. Every request returns one pose. One
// request is worked on at a time, using the bit-serial datapath (shift-add
// multiplier, restoring divider and the 24-step CORDIC). The next request is
// taken while the previous pose still waits in the output register. The user
// must write configuration through i_cfg_* only while no request is in work;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Top level: sequencer, pose state and the serial arithmetic units.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int ANGLE_BITS = 24,
    parameter int POS_BITS   = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ddo_in_if.sink                            i_req,
    ddo_out_if.source                         o_pose
);

    localparam int ASH    = 32 - ANGLE_BITS;
    localparam int STEP_W = 34;
    localparam int SW     = ((POS_BITS > STEP_W + 1) ? POS_BITS : STEP_W + 1) + 1;
    localparam logic [SW-1:0] PMAX = {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
    localparam logic [SW-1:0] PMIN = {{(SW - POS_BITS + 1){1'b1}}, {(POS_BITS - 1){1'b0}}};

    ddo_pkg::t_state r_state, n_state;
    logic r_go, n_go;
    logic r_wheel;

    logic [ddo_pkg::CPR_W-1:0]        r_cpr;
    logic [ddo_pkg::RAD_W-1:0]        r_rad;
    logic [ddo_pkg::TRK_W-1:0]        r_trk;
    logic signed [ddo_pkg::RATE_W-1:0] r_lrate;
    logic signed [ddo_pkg::RATE_W-1:0] r_rrate;
    logic [ddo_pkg::DT_W-1:0]         r_dt;
    logic [ddo_pkg::SPD_W-1:0]        r_lspd;
    logic [ddo_pkg::SPD_W-1:0]        r_rspd;
    logic [POS_BITS-1:0]              r_px;
    logic [POS_BITS-1:0]              r_py;
    logic [ANGLE_BITS-1:0]            r_hd;
    logic                             r_ov;
    logic [POS_BITS-1:0]              r_ox;
    logic [POS_BITS-1:0]              r_oy;
    logic [ANGLE_BITS-1:0]            r_oh;

    // unit hookups
    logic                             w_mul_start, w_mul_done;
    logic [ddo_pkg::MUL_A_W-1:0]      w_mul_a;
    logic [ddo_pkg::MUL_B_W-1:0]      w_mul_b;
    logic [ddo_pkg::MUL_P_W-1:0]      w_mul_p;
    logic                             w_div_start, w_div_done;
    logic [ddo_pkg::DIV_N_W-1:0]      w_div_n;
    logic [ddo_pkg::DIV_D_W-1:0]      w_div_d;
    logic [ddo_pkg::DIV_N_W-1:0]      w_div_q;
    logic                             w_cor_start, w_cor_done;
    logic [31:0]                      w_turn;
    logic signed [ddo_pkg::TRIG_W-1:0] w_cos, w_sin;

    logic                             w_done, w_work, w_fin;
    logic [ddo_pkg::CPR_W-1:0]        w_cpr_eff;
    logic [ddo_pkg::TRK_W-1:0]        w_trk_eff;
    logic signed [ddo_pkg::RATE_W-1:0] w_rate;
    logic                             w_rneg;
    logic [ddo_pkg::RATE_W-1:0]       w_rmag;
    logic [ddo_pkg::SPD_W-1:0]        w_spd;
    logic [ddo_pkg::SPD_W:0]          w_sum, w_dif;
    logic                             w_sneg, w_dneg;
    logic [ddo_pkg::SPD_W:0]          w_smag, w_dmag;
    logic                             w_cneg, w_tneg;
    logic [ddo_pkg::TRIG_W-1:0]       w_cmag, w_tmag;
    logic [79:0]                      w_prnd;
    logic [STEP_W-1:0]                w_step;
    logic [63:0]                      w_afull;
    logic [31:0]                      w_a32;
    logic [ANGLE_BITS-1:0]            w_hstep;

    // saturating position update
    function automatic logic [POS_BITS-1:0] f_sat_add(input logic [POS_BITS-1:0] pos,
                                                       input logic neg,
                                                       input logic [STEP_W-1:0] mag);
        logic [SW-1:0] pe;
        logic [SW-1:0] de;
        logic [SW-1:0] sm;
        logic [POS_BITS-1:0] res;
        pe = {{(SW - POS_BITS){pos[POS_BITS-1]}}, pos};
        de = SW'(mag);
        if (neg) begin
            de = ~de + SW'(1);
        end
        sm = pe + de;
        if ($signed(sm) > $signed(PMAX)) begin
            res = PMAX[POS_BITS-1:0];
        end else if ($signed(sm) < $signed(PMIN)) begin
            res = PMIN[POS_BITS-1:0];
        end else begin
            res = sm[POS_BITS-1:0];
        end
        return res;
    endfunction

    // arithmetic units
    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (w_div_d),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_turn  (w_turn),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // zero divisors act as one
    assign w_cpr_eff = (r_cpr == '0) ? ddo_pkg::CPR_W'(1) : r_cpr;
    assign w_trk_eff = (r_trk == '0) ? ddo_pkg::TRK_W'(1) : r_trk;

    // rate magnitude of the wheel in work
    assign w_rate = r_wheel ? r_rrate : r_lrate;
    assign w_rneg = w_rate[ddo_pkg::RATE_W-1];
    assign w_rmag = w_rneg ? ddo_pkg::RATE_W'(-w_rate) : ddo_pkg::RATE_W'(w_rate);

    // speed from quotient, saturated and signed
    always_comb begin
        if (w_rneg) begin
            if (w_div_q > 64'(ddo_pkg::SPD_MIN)) begin
                w_spd = ddo_pkg::SPD_MIN;
            end else begin
                w_spd = -w_div_q[ddo_pkg::SPD_W-1:0];
            end
        end else begin
            if (w_div_q > 64'(ddo_pkg::SPD_MAX)) begin
                w_spd = ddo_pkg::SPD_MAX;
            end else begin
                w_spd = w_div_q[ddo_pkg::SPD_W-1:0];
            end
        end
    end

    // sum and difference of the wheel speeds
    assign w_sum  = {r_lspd[ddo_pkg::SPD_W-1], r_lspd} + {r_rspd[ddo_pkg::SPD_W-1], r_rspd};
    assign w_dif  = {r_lspd[ddo_pkg::SPD_W-1], r_lspd} - {r_rspd[ddo_pkg::SPD_W-1], r_rspd};
    assign w_sneg = w_sum[ddo_pkg::SPD_W];
    assign w_dneg = w_dif[ddo_pkg::SPD_W];
    assign w_smag = w_sneg ? -w_sum : w_sum;
    assign w_dmag = w_dneg ? -w_dif : w_dif;

    // trig magnitudes and signs
    assign w_cneg = w_cos[ddo_pkg::TRIG_W-1];
    assign w_tneg = w_sin[ddo_pkg::TRIG_W-1];
    assign w_cmag = w_cneg ? ddo_pkg::TRIG_W'(-w_cos) : ddo_pkg::TRIG_W'(w_cos);
    assign w_tmag = w_tneg ? ddo_pkg::TRIG_W'(-w_sin) : ddo_pkg::TRIG_W'(w_sin);

    // position step, rounded by 2^46
    assign w_prnd = w_mul_p[79:0] + (80'd1 << 45);
    assign w_step = w_prnd[79:46];

    // heading step from radians times turns per radian
    assign w_afull = w_mul_p[63:0] + (64'd1 << 29);
    assign w_a32   = w_afull[61:30];
    assign w_turn  = 32'(r_hd) << ASH;

    generate
        if (ASH == 0) begin : g_full
            assign w_hstep = w_a32[ANGLE_BITS-1:0];
        end else begin : g_rnd
            logic [32:0] w_ar;
            assign w_ar    = {1'b0, w_a32} + (33'd1 << (ASH - 1));
            assign w_hstep = w_ar[ASH +: ANGLE_BITS];
        end
    endgenerate

    // unit handshake of the sequencer
    assign w_done = w_mul_done | w_div_done | w_cor_done;
    assign w_work = (r_state != ddo_pkg::ST_IDLE) && (r_state != ddo_pkg::ST_OUT);
    assign w_fin  = r_go && w_done;
    assign n_go   = w_work && !w_fin;

    // next state and unit operands
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_n     = '0;
        w_div_d     = ddo_pkg::US_DIV;
        w_cor_start = 1'b0;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = i_req.action ? ddo_pkg::ST_T_TRIG : ddo_pkg::ST_R_MUL1;
                end
            end
            ddo_pkg::ST_R_MUL1: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_rmag);
                w_mul_b     = 32'(r_rad);
                if (w_fin) n_state = ddo_pkg::ST_R_MUL2;
            end
            ddo_pkg::ST_R_MUL2: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_mul_p[43:0]);
                w_mul_b     = ddo_pkg::TWO_PI_Q16;
                if (w_fin) n_state = ddo_pkg::ST_R_DIV;
            end
            ddo_pkg::ST_R_DIV: begin
                w_div_start = !r_go;
                w_div_n     = w_mul_p[63:0] + (64'(w_cpr_eff) << 15);
                w_div_d     = {w_cpr_eff, 16'h0000};
                if (w_fin) n_state = r_wheel ? ddo_pkg::ST_OUT : ddo_pkg::ST_R_MUL1;
            end
            ddo_pkg::ST_T_TRIG: begin
                w_cor_start = !r_go;
                if (w_fin) n_state = ddo_pkg::ST_T_MULS;
            end
            ddo_pkg::ST_T_MULS: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_smag);
                w_mul_b     = 32'(r_dt);
                if (w_fin) n_state = ddo_pkg::ST_T_DIVS;
            end
            ddo_pkg::ST_T_DIVS: begin
                w_div_start = !r_go;
                w_div_n     = (w_mul_p[63:0] << 9) + ddo_pkg::US_ROUND;
                if (w_fin) n_state = ddo_pkg::ST_T_MULX;
            end
            ddo_pkg::ST_T_MULX: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_div_q[47:0]);
                w_mul_b     = 32'(w_cmag);
                if (w_fin) n_state = ddo_pkg::ST_T_MULY;
            end
            ddo_pkg::ST_T_MULY: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_div_q[47:0]);
                w_mul_b     = 32'(w_tmag);
                if (w_fin) n_state = ddo_pkg::ST_T_MULD;
            end
            ddo_pkg::ST_T_MULD: begin
                w_mul_start = !r_go;
                w_mul_a     = 64'(w_dmag);
                w_mul_b     = 32'(r_dt);
                if (w_fin) n_state = ddo_pkg::ST_T_DIVD;
            end
            ddo_pkg::ST_T_DIVD: begin
                w_div_start = !r_go;
                w_div_n     = (w_mul_p[63:0] << 4) + ddo_pkg::US_ROUND;
                if (w_fin) n_state = ddo_pkg::ST_T_DIVR;
            end
            ddo_pkg::ST_T_DIVR: begin
                w_div_start = !r_go;
                w_div_n     = (w_div_q << 20) + 64'(w_trk_eff >> 1);
                w_div_d     = 32'(w_trk_eff);
                if (w_fin) n_state = ddo_pkg::ST_T_MULA;
            end
            ddo_pkg::ST_T_MULA: begin
                w_mul_start = !r_go;
                w_mul_a     = w_div_q;
                w_mul_b     = ddo_pkg::TURN_PER_RAD;
                if (w_fin) n_state = ddo_pkg::ST_OUT;
            end
            ddo_pkg::ST_OUT: begin
                if (!r_ov || o_pose.ready) n_state = ddo_pkg::ST_IDLE;
            end
            default: begin
                n_state = ddo_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr <= ddo_pkg::CPR_RESET;
            r_rad <= ddo_pkg::RAD_RESET;
            r_trk <= ddo_pkg::TRK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ddo_pkg::CFG_CPR: r_cpr <= i_cfg_data[ddo_pkg::CPR_W-1:0];
                ddo_pkg::CFG_RAD: r_rad <= i_cfg_data[ddo_pkg::RAD_W-1:0];
                ddo_pkg::CFG_TRK: r_trk <= i_cfg_data[ddo_pkg::TRK_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_lrate <= i_req.left_rate;
            r_rrate <= i_req.right_rate;
            r_dt    <= i_req.elapsed_us;
        end
    end

    // speeds, pose and heading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel <= 1'b0;
            r_lspd  <= '0;
            r_rspd  <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_hd    <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_wheel <= 1'b0;
            end
            if (w_fin) begin
                case (r_state)
                    ddo_pkg::ST_R_DIV: begin
                        if (r_wheel) r_rspd <= w_spd;
                        else         r_lspd <= w_spd;
                        r_wheel <= ~r_wheel;
                    end
                    ddo_pkg::ST_T_MULX: r_px <= f_sat_add(r_px, w_sneg ^ w_cneg, w_step);
                    ddo_pkg::ST_T_MULY: r_py <= f_sat_add(r_py, w_sneg ^ w_tneg, w_step);
                    ddo_pkg::ST_T_MULA: r_hd <= w_dneg ? r_hd - w_hstep : r_hd + w_hstep;
                    default: ;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ddo_pkg::ST_OUT && (!r_ov || o_pose.ready)) begin
            r_ov <= 1'b1;
        end else if (o_pose.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddo_pkg::ST_OUT && (!r_ov || o_pose.ready)) begin
            r_ox <= r_px;
            r_oy <= r_py;
            r_oh <= r_hd;
        end
    end

    assign i_req.ready      = (r_state == ddo_pkg::ST_IDLE);
    assign o_pose.valid     = r_ov;
    assign o_pose.pose_x_um = r_ox;
    assign o_pose.pose_y_um = r_oy;
    assign o_pose.heading   = r_oh;

endmodule

[tb/tb_differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the odometry block: rate and tick requests are
// queued, driven with random gaps and checked against an in-bench pose
// predictor under several register settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;

    localparam int POS_W = 40;
    localparam int ANG_W = 24;
    localparam logic ACT_RATE = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic [ddo_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic                       action;
        logic [ddo_pkg::RATE_W-1:0] left_rate;
        logic [ddo_pkg::RATE_W-1:0] right_rate;
        logic [ddo_pkg::DT_W-1:0]   elapsed_us;
    } t_request;

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ANG_W-1:0] hdg;
    } t_pose;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ddo_in_if req_if ();
    ddo_out_if #(.POS_BITS(POS_W), .ANGLE_BITS(ANG_W)) pose_if ();

    differential_drive_odometry #(.ANGLE_BITS(ANG_W), .POS_BITS(POS_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_pose     (pose_if)
    );

    t_request pending_reqs[$];
    t_pose    expected_poses[$];
    int       errors;
    int       src_idle_pct;
    int       dst_stall_pct;

    // predictor copy of registers and pose state
    bit [63:0] mdl_cpr, mdl_rad, mdl_trk;
    longint    mdl_left, mdl_right, mdl_x, mdl_y;
    bit [63:0] mdl_hdg;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // wheel surface speed in um/s from a signed pulse rate
    function automatic longint wheel_speed(logic [ddo_pkg::RATE_W-1:0] raw);
        bit [63:0] mag, cpr, prod, den, q;
        mag  = raw[ddo_pkg::RATE_W-1] ? (64'h100_0000 - 64'(raw)) : 64'(raw);
        cpr  = (mdl_cpr != 0) ? mdl_cpr : 64'd1;
        prod = mag * mdl_rad * 64'd411775;
        den  = cpr << 16;
        q    = (prod + den / 2) / den;
        if (raw[ddo_pkg::RATE_W-1]) begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return -longint'(q);
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return longint'(q);
    endfunction

    // rotation cordic, q30 results, folded by half a turn
    function automatic void sin_cos(input bit [31:0] turn, output longint c,
                                    output longint s);
        bit [31:0] z;
        bit        flip;
        longint    x, y, zs, dx, dy;
        longint    atans[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                 333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                                 1304, 652, 326, 163, 81};
        z = turn;
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (flip) z = z ^ 32'h8000_0000;
        zs = longint'(signed'(z));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (zs >= 0) begin
                x = x - dx; y = y + dy; zs = zs - atans[i];
            end else begin
                x = x + dx; y = y - dy; zs = zs + atans[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // signed axis step: round(distq * |trig| / 2^46)
    function automatic longint axis_step(bit [63:0] distq, bit sneg, longint trig);
        bit [63:0] tmag, lo, hi, p;
        tmag = (trig < 0) ? 64'(-trig) : 64'(trig);
        lo = {32'd0, distq[31:0]} * tmag;
        hi = (distq >> 32) * tmag;
        p  = (hi + ((lo + (64'd1 << 45)) >> 32)) >> 14;
        return (sneg != (trig < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp_pos(longint p, longint d);
        longint pmax, v;
        pmax = (longint'(1) <<< (POS_W - 1)) - 1;
        v = p + d;
        if (v > pmax) return pmax;
        if (v < -pmax - 1) return -pmax - 1;
        return v;
    endfunction

    // advance the pose by one tick
    function automatic void integrate_tick(input bit [63:0] dt);
        longint    sum, diff, c, s;
        bit [63:0] smag, dmag, distq, trk, g, r, a32, stepv;
        sum  = mdl_left + mdl_right;
        diff = mdl_left - mdl_right;
        smag = (sum < 0) ? 64'(-sum) : 64'(sum);
        dmag = (diff < 0) ? 64'(-diff) : 64'(diff);
        distq = (smag * dt * 64'd512 + 64'd7812) / 64'd15625;
        trk  = (mdl_trk != 0) ? mdl_trk : 64'd1;
        g    = (dmag * dt * 64'd16 + 64'd7812) / 64'd15625;
        r    = ((g << 20) + trk / 2) / trk;
        a32  = ((r * 64'd683565276 + (64'd1 << 29)) >> 30) & 64'hFFFF_FFFF;
        sin_cos(32'(mdl_hdg << (32 - ANG_W)), c, s);
        mdl_x = clamp_pos(mdl_x, axis_step(distq, sum < 0, c));
        mdl_y = clamp_pos(mdl_y, axis_step(distq, sum < 0, s));
        stepv = (a32 + (64'd1 << (31 - ANG_W))) >> (32 - ANG_W);
        if (diff < 0) mdl_hdg = (mdl_hdg - stepv) & ((64'd1 << ANG_W) - 1);
        else          mdl_hdg = (mdl_hdg + stepv) & ((64'd1 << ANG_W) - 1);
    endfunction

    function automatic t_pose next_pose(t_request rq);
        t_pose p;
        if (rq.action == ACT_RATE) begin
            mdl_left  = wheel_speed(rq.left_rate);
            mdl_right = wheel_speed(rq.right_rate);
        end else begin
            integrate_tick(64'(rq.elapsed_us));
        end
        p.x   = mdl_x[POS_W-1:0];
        p.y   = mdl_y[POS_W-1:0];
        p.hdg = mdl_hdg[ANG_W-1:0];
        return p;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.action     <= ACT_RATE;
            req_if.left_rate  <= '0;
            req_if.right_rate <= '0;
            req_if.elapsed_us <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                rq = pending_reqs.pop_front();
                req_if.valid      <= 1'b1;
                req_if.action     <= rq.action;
                req_if.left_rate  <= rq.left_rate;
                req_if.right_rate <= rq.right_rate;
                req_if.elapsed_us <= rq.elapsed_us;
                expected_poses.push_back(next_pose(rq));
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // pose monitor
    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            pose_if.ready <= 1'b0;
        end else begin
            if (pose_if.valid && pose_if.ready) begin
                if (expected_poses.size() == 0) begin
                    $error("pose with no request outstanding");
                    errors++;
                end else begin
                    e = expected_poses.pop_front();
                    if (pose_if.pose_x_um !== e.x) begin
                        $error("pose_x_um expected %0d got %0d", $signed(e.x),
                               pose_if.pose_x_um);
                        errors++;
                    end
                    if (pose_if.pose_y_um !== e.y) begin
                        $error("pose_y_um expected %0d got %0d", $signed(e.y),
                               pose_if.pose_y_um);
                        errors++;
                    end
                    if (pose_if.heading !== e.hdg) begin
                        $error("heading expected %0d got %0d", e.hdg, pose_if.heading);
                        errors++;
                    end
                end
            end
            pose_if.ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // register write, idle only
    task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ddo_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            ddo_pkg::CFG_CPR: mdl_cpr = 64'(val[ddo_pkg::CPR_W-1:0]);
            ddo_pkg::CFG_RAD: mdl_rad = 64'(val[ddo_pkg::RAD_W-1:0]);
            ddo_pkg::CFG_TRK: mdl_trk = 64'(val[ddo_pkg::TRK_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int cpr, input int rad, input int trk);
        write_reg(ddo_pkg::CFG_CPR, ddo_pkg::CFG_DATA_W'(cpr));
        write_reg(ddo_pkg::CFG_RAD, ddo_pkg::CFG_DATA_W'(rad));
        write_reg(ddo_pkg::CFG_TRK, ddo_pkg::CFG_DATA_W'(trk));
    endtask

    // wait until every request is answered, then let the block settle
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_poses.size() > 0 || req_if.valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_rate(input logic [ddo_pkg::RATE_W-1:0] l,
                             input logic [ddo_pkg::RATE_W-1:0] r);
        t_request rq;
        rq.action = ACT_RATE;
        rq.left_rate = l;
        rq.right_rate = r;
        rq.elapsed_us = ddo_pkg::DT_W'($urandom);
        pending_reqs.push_back(rq);
    endtask

    task automatic push_tick(input logic [ddo_pkg::DT_W-1:0] dt);
        t_request rq;
        rq.action = ACT_TICK;
        rq.left_rate = ddo_pkg::RATE_W'($urandom);
        rq.right_rate = ddo_pkg::RATE_W'($urandom);
        rq.elapsed_us = dt;
        pending_reqs.push_back(rq);
    endtask

    // random mix: mostly small rates and ticks, some full-range values
    task automatic push_random(input int n);
        logic [ddo_pkg::RATE_W-1:0] l, r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(3) == 0) begin
                    l = ddo_pkg::RATE_W'($urandom);
                    r = ddo_pkg::RATE_W'($urandom);
                end else begin
                    l = ddo_pkg::RATE_W'($signed($urandom_range(20000)) - 10000);
                    r = ddo_pkg::RATE_W'($signed($urandom_range(20000)) - 10000);
                end
                push_rate(l, r);
            end else begin
                push_tick(($urandom_range(3) == 0) ? ddo_pkg::DT_W'($urandom)
                                                  : ddo_pkg::DT_W'($urandom_range(2000)));
            end
        end
    endtask

    // main sequence
    initial begin
        errors = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ddo_pkg::CFG_CPR;
        i_cfg_data = '0;
        mdl_cpr = 64'd6000; mdl_rad = 64'd47500; mdl_trk = 64'd350000;
        mdl_left = 0; mdl_right = 0; mdl_x = 0; mdl_y = 0; mdl_hdg = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, rate extremes, tick extremes
        push_tick(20'd1000);
        push_rate(24'h7FFFFF, 24'h800000);
        push_tick(20'd0);
        push_tick(20'hFFFFF);
        push_rate(24'h800000, 24'h7FFFFF);
        push_tick(20'hFFFFF);
        push_rate(24'd0, 24'd0);
        push_tick(20'hFFFFF);
        push_rate(24'd3000, 24'd2000);
        for (int i = 0; i < 6; i++) push_tick(20'd250000);
        wait_drained();

        // zero counts, zero track, out-of-range index, bits above width
        write_reg(ddo_pkg::CFG_CPR, 22'h3F_0000);
        write_reg(ddo_pkg::CFG_TRK, 22'd0);
        write_reg(CFG_NONE, 22'h3F_FFFF);
        push_rate(24'd5, 24'hFFFFFB);
        push_tick(20'd1000);
        push_tick(20'hFFFFF);
        wait_drained();
        // zero radius gives zero speed
        write_reg(ddo_pkg::CFG_RAD, 22'h30_0000);
        push_rate(24'h7FFFFF, 24'h123456);
        push_tick(20'hFFFFF);
        wait_drained();

        // speed overflow, then straight line run into the position limit
        set_regs(1, 1000000, 4000000);
        push_rate(24'h7FFFFF, 24'h7FFFFF);
        for (int i = 0; i < 300; i++) push_tick(20'd1000000);
        wait_drained();

        // random phases across settings and handshake pressure
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  set_regs(6000, 47500, 350000); end
                1: begin src_idle_pct = 57; dst_stall_pct = 0;
                         set_regs($urandom_range(65535), $urandom_range(1000000),
                                  $urandom_range(4000000)); end
                2: begin src_idle_pct = 0;  dst_stall_pct = 57; set_regs(65535, 1048575, 4194303); end
                default: begin src_idle_pct = 9; dst_stall_pct = 9; set_regs(1, 1, 1); end
            endcase
            push_random(16);
            if (ph == 1) wait_drained();
            push_random(16);
            wait_drained();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hdl/ddo_pkg.sv
hdl/ddo_in_if.sv
hdl/ddo_out_if.sv
hdl/ddo_mul.sv
hdl/ddo_div.sv
hdl/ddo_cordic.sv
hdl/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
